// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types for the quadratic root solver: the root kind codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

   typedef enum logic [1:0] {
      KIND_TWO_REAL = 2'd0,
      KIND_DOUBLE   = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_ERROR    = 2'd3
   } root_kind_type;

endpackage

// ===== design/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c for signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one coefficient set a, b, c per transfer.
//   Result channel rsp_*: one transfer per input, in input order, carrying
//   both roots as real and imaginary parts, root_kind and saturated.
//   Pipeline from input transfer to rsp_valid: 4 discriminant stages, one
//   stage per root bit in the square root, 2 numerator stages, one stage per
//   quotient bit in the two dividers, 1 rounding and output stage; the first
//   stage loads at the input transfer edge.
//   Throughput: one set per cycle unless rsp stalls. All stages move on one
//   enable, so the rate is set by the output register alone.
//   Stall: while rsp_valid is high and rsp_ready low, the whole pipeline
//   holds and req_ready drops; nothing is lost or repeated.
//   Reset: clears every stage valid bit; the pipeline comes up empty and
//   takes an item in the first cycle after reset.
//   Zero a gives root_kind error with all roots and saturated at zero.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
   parameter int COEFF_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COEFF_WIDTH-1:0] req_coeff_a,
   input  logic [COEFF_WIDTH-1:0] req_coeff_b,
   input  logic [COEFF_WIDTH-1:0] req_coeff_c,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COEFF_WIDTH-1:0] rsp_first_real,
   output logic [COEFF_WIDTH-1:0] rsp_first_imag,
   output logic [COEFF_WIDTH-1:0] rsp_second_real,
   output logic [COEFF_WIDTH-1:0] rsp_second_imag,
   output logic [1:0]             rsp_root_kind,
   output logic                   rsp_saturated
);

   import qrs_pkg::*;

   localparam int CW   = COEFF_WIDTH;
   localparam int FB   = FRAC_BITS;
   localparam int DW   = 2 * CW + 1;      // discriminant magnitude
   localparam int SW   = CW + FB + 1;     // square root width
   localparam int NW   = SW + 2;          // signed numerator width
   localparam int QW   = SW + 3;          // divider numerator and quotient
   localparam int DENW = CW + 2;          // divider denominator 4*|a|
   localparam int T1W  = 2 * CW + 4;

   // global advance: every stage moves unless a result is stuck
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------- discriminant ----------------
   logic          d_valid, d_neg, d_zero, d_aneg, d_bneg;
   logic [DW-1:0] d_mag;
   logic [CW-1:0] d_am, d_bm;

   qrs_disc #(.CW(CW)) u_disc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_a      (req_coeff_a),
      .in_b      (req_coeff_b),
      .in_c      (req_coeff_c),
      .out_valid (d_valid),
      .out_mag   (d_mag),
      .out_neg   (d_neg),
      .out_zero  (d_zero),
      .out_am    (d_am),
      .out_aneg  (d_aneg),
      .out_bm    (d_bm),
      .out_bneg  (d_bneg)
   );

   // ---------------- square root of |D| * 2^(2*FB) ----------------
   logic [2*SW-1:0] s_rad;
   logic [T1W-1:0]  s_tag_in, s_tag;
   logic            s_valid;
   logic [SW-1:0]   s_root;

   assign s_rad    = (2 * SW)'(d_mag) << (2 * FB);
   assign s_tag_in = {d_am, d_bm, d_aneg, d_bneg, d_neg, d_zero};

   qrs_sqrt #(.SW(SW), .TAG_W(T1W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_rad    (s_rad),
      .in_tag    (s_tag_in),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_tag   (s_tag)
   );

   // ---------------- numerator stage 1: -B*2^FB +/- S ----------------
   logic [CW-1:0]        t_am, t_bm;
   logic                 t_aneg, t_bneg, t_dneg, t_dzero;
   logic signed [NW-1:0] nb_mag, nb_s, s_s;
   root_kind_type        kind_c;

   assign {t_am, t_bm, t_aneg, t_bneg, t_dneg, t_dzero} = s_tag;
   assign nb_mag = NW'(t_bm) << FB;
   assign nb_s   = t_bneg ? nb_mag : -nb_mag;   // this is -B
   assign s_s    = NW'(s_root);

   always_comb begin
      if (t_am == '0) begin
         kind_c = KIND_ERROR;
      end else if (t_dzero) begin
         kind_c = KIND_DOUBLE;
      end else if (t_dneg) begin
         kind_c = KIND_COMPLEX;
      end else begin
         kind_c = KIND_TWO_REAL;
      end
   end

   logic                 c1_valid_ff;
   logic signed [NW-1:0] n1_ff, n2_ff, nb_ff, sv_ff;
   logic [CW-1:0]        c1_am_ff;
   logic                 c1_aneg_ff;
   root_kind_type        c1_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else if (en) begin
         c1_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff      <= nb_s - s_s;
         n2_ff      <= nb_s + s_s;
         nb_ff      <= nb_s;
         sv_ff      <= s_s;
         c1_am_ff   <= t_am;
         c1_aneg_ff <= t_aneg;
         c1_kind_ff <= kind_c;
      end
   end

   // ---------------- numerator stage 2: 2|N| + 2|A|, den 4|A| ----------------
   logic signed [NW-1:0] x_sel, y_sel;
   logic [NW-2:0]        x_mag, y_mag;
   logic                 x_flag, y_flag;
   logic [QW-1:0]        am_q;

   assign x_sel  = (c1_kind_ff == KIND_TWO_REAL) ? n1_ff : nb_ff;
   assign y_sel  = (c1_kind_ff == KIND_TWO_REAL) ? n2_ff : sv_ff;
   assign x_mag  = x_sel[NW-1] ? (NW-1)'(-x_sel) : x_sel[NW-2:0];
   assign y_mag  = y_sel[NW-1] ? (NW-1)'(-y_sel) : y_sel[NW-2:0];
   assign x_flag = x_sel[NW-1] ^ c1_aneg_ff;
   // complex pair: y carries sign of a; first imag takes the opposite
   assign y_flag = (c1_kind_ff == KIND_TWO_REAL) ? (y_sel[NW-1] ^ c1_aneg_ff)
                                                 : c1_aneg_ff;
   assign am_q   = QW'(c1_am_ff);

   logic          c2_valid_ff;
   logic [QW-1:0] numx_ff, numy_ff;
   logic [DENW-1:0] den_ff;
   logic [2:0]    xtag_ff;
   logic          ytag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_valid_ff <= 1'b0;
      end else if (en) begin
         c2_valid_ff <= c1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= (QW'(x_mag) << 1) + (am_q << 1);
         numy_ff <= (QW'(y_mag) << 1) + (am_q << 1);
         den_ff  <= {c1_am_ff, 2'b00};
         xtag_ff <= {c1_kind_ff, x_flag};
         ytag_ff <= y_flag;
      end
   end

   // ---------------- dividers ----------------
   logic          qx_valid, qy_valid;
   logic [QW-1:0] qx, qy;
   logic [2:0]    qx_tag;
   logic          qy_tag;

   qrs_div #(.NUMW(QW), .DENW(DENW), .TAG_W(3)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c2_valid_ff),
      .in_num    (numx_ff),
      .in_den    (den_ff),
      .in_tag    (xtag_ff),
      .out_valid (qx_valid),
      .out_quo   (qx),
      .out_tag   (qx_tag)
   );

   qrs_div #(.NUMW(QW), .DENW(DENW), .TAG_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c2_valid_ff),
      .in_num    (numy_ff),
      .in_den    (den_ff),
      .in_tag    (ytag_ff),
      .out_valid (qy_valid),
      .out_quo   (qy),
      .out_tag   (qy_tag)
   );

   // ---------------- rounding, saturation, output register ----------------
   function automatic logic [CW:0] round_sat(input logic [QW-1:0] q, input logic neg);
      logic [QW-1:0] lim;
      logic [QW-1:0] qs;
      logic          sat;
      logic [CW-1:0] v;
      lim = neg ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
      sat = (q > lim);
      qs  = sat ? lim : q;
      v   = qs[CW-1:0];
      if (neg) begin
         v = ~v + 1'b1;
      end
      return {sat, v};
   endfunction

   root_kind_type f_kind;
   logic [CW:0]   px, py, pyn;
   logic [CW-1:0] fr_in, fi_in, sr_in, si_in;
   logic          sat_in;

   assign f_kind = root_kind_type'(qx_tag[2:1]);
   assign px     = round_sat(qx, qx_tag[0]);
   assign py     = round_sat(qy, qy_tag);
   assign pyn    = round_sat(qy, !qy_tag);

   always_comb begin
      fr_in  = '0;
      fi_in  = '0;
      sr_in  = '0;
      si_in  = '0;
      sat_in = 1'b0;
      case (f_kind)
         KIND_TWO_REAL: begin
            fr_in  = px[CW-1:0];
            sr_in  = py[CW-1:0];
            sat_in = px[CW] | py[CW];
         end
         KIND_DOUBLE: begin
            fr_in  = px[CW-1:0];
            sr_in  = px[CW-1:0];
            sat_in = px[CW];
         end
         KIND_COMPLEX: begin
            fr_in  = px[CW-1:0];
            sr_in  = px[CW-1:0];
            fi_in  = pyn[CW-1:0];
            si_in  = py[CW-1:0];
            sat_in = px[CW] | py[CW] | pyn[CW];
         end
         default: begin
            // zero a: roots stay cleared
         end
      endcase
   end

   logic          rsp_valid_ff;
   logic [CW-1:0] fr_ff, fi_ff, sr_ff, si_ff;
   logic [1:0]    kind_ff;
   logic          sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= qx_valid & qy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fr_ff   <= fr_in;
         fi_ff   <= fi_in;
         sr_ff   <= sr_in;
         si_ff   <= si_in;
         kind_ff <= f_kind;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_real  = fr_ff;
   assign rsp_first_imag  = fi_ff;
   assign rsp_second_real = sr_ff;
   assign rsp_second_imag = si_ff;
   assign rsp_root_kind   = kind_ff;
   assign rsp_saturated   = sat_ff;

`ifndef SYNTH
   a_error_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_ERROR |->
         rsp_first_real == '0 && rsp_second_real == '0 && rsp_first_imag == '0
         && rsp_second_imag == '0 && !rsp_saturated)
      else $error("zero a result carries nonzero fields");

   a_real_imag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_TWO_REAL |->
         rsp_first_imag == '0 && rsp_second_imag == '0)
      else $error("real roots carry imaginary parts");

   a_double_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_DOUBLE |->
         rsp_first_real == rsp_second_real && rsp_first_imag == '0)
      else $error("double root parts differ");

   a_conjugate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_COMPLEX && !rsp_saturated |->
         rsp_first_imag == (~rsp_second_imag + 1'b1)
         && rsp_first_real == rsp_second_real)
      else $error("complex pair is not conjugate");
`endif

endmodule

// ===== design/qrs_disc.sv =====
// ----------------------------------------------------------------------------
// qrs_disc
// Four-stage discriminant unit: magnitudes, split partial products,
// product sums, then |b*b - 4*a*c| with its sign and zero flag.
// ----------------------------------------------------------------------------
module qrs_disc #(
   parameter int CW = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [CW-1:0]     in_a,
   input  logic [CW-1:0]     in_b,
   input  logic [CW-1:0]     in_c,
   output logic              out_valid,
   output logic [2*CW:0]     out_mag,
   output logic              out_neg,
   output logic              out_zero,
   output logic [CW-1:0]     out_am,
   output logic              out_aneg,
   output logic [CW-1:0]     out_bm,
   output logic              out_bneg
);

   localparam int H  = (CW + 1) / 2;
   localparam int PW = 2 * H;
   localparam int DW = 2 * CW + 1;

   // stage 1: magnitudes
   logic          v1_ff;
   logic [CW-1:0] am1_ff, bm1_ff, cm1_ff;
   logic          an1_ff, bn1_ff, cn1_ff;

   // stage 2: partial products
   logic          v2_ff;
   logic [PW-1:0] bll_ff, blh_ff, bhh_ff, all_ff, alh_ff, ahl_ff, ahh_ff;
   logic [CW-1:0] am2_ff, bm2_ff;
   logic          an2_ff, bn2_ff, sd2_ff;

   // stage 3: full products
   logic            v3_ff;
   logic [2*CW-2:0] bb3_ff, ac3_ff;
   logic [CW-1:0]   am3_ff, bm3_ff;
   logic            an3_ff, bn3_ff, sd3_ff;

   // stage 4: discriminant
   logic          v4_ff;
   logic [DW-1:0] mag4_ff;
   logic          neg4_ff, zero4_ff;
   logic [CW-1:0] am4_ff, bm4_ff;
   logic          an4_ff, bn4_ff;

   logic [PW-1:0]   ax, bx;
   logic [2*PW-1:0] bb_sum, ac_sum;
   logic [DW-1:0]   bb_w, ac4_w, add_w, sub_ba, sub_ab;

   assign ax = PW'(am1_ff);
   assign bx = PW'(bm1_ff);

   assign bb_sum = {bhh_ff, {PW{1'b0}}}
                 + ({{PW{1'b0}}, blh_ff} << (H + 1))
                 + {{PW{1'b0}}, bll_ff};
   assign ac_sum = {ahh_ff, {PW{1'b0}}}
                 + (({{PW{1'b0}}, alh_ff} + {{PW{1'b0}}, ahl_ff}) << H)
                 + {{PW{1'b0}}, all_ff};

   assign bb_w   = DW'(bb3_ff);
   assign ac4_w  = {ac3_ff, 2'b00};
   assign add_w  = bb_w + ac4_w;
   assign sub_ba = bb_w - ac4_w;
   assign sub_ab = ac4_w - bb_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an1_ff <= in_a[CW-1];
         bn1_ff <= in_b[CW-1];
         cn1_ff <= in_c[CW-1];
         am1_ff <= in_a[CW-1] ? (~in_a + 1'b1) : in_a;
         bm1_ff <= in_b[CW-1] ? (~in_b + 1'b1) : in_b;
         cm1_ff <= in_c[CW-1] ? (~in_c + 1'b1) : in_c;

         bll_ff <= bx[H-1:0] * bx[H-1:0];
         blh_ff <= bx[H-1:0] * bx[PW-1:H];
         bhh_ff <= bx[PW-1:H] * bx[PW-1:H];
         all_ff <= ax[H-1:0] * PW'(cm1_ff[H-1:0]);
         alh_ff <= ax[H-1:0] * (PW'(cm1_ff) >> H);
         ahl_ff <= ax[PW-1:H] * PW'(cm1_ff[H-1:0]);
         ahh_ff <= ax[PW-1:H] * (PW'(cm1_ff) >> H);
         am2_ff <= am1_ff;
         bm2_ff <= bm1_ff;
         an2_ff <= an1_ff;
         bn2_ff <= bn1_ff;
         sd2_ff <= an1_ff ^ cn1_ff;

         bb3_ff <= bb_sum[2*CW-2:0];
         ac3_ff <= ac_sum[2*CW-2:0];
         am3_ff <= am2_ff;
         bm3_ff <= bm2_ff;
         an3_ff <= an2_ff;
         bn3_ff <= bn2_ff;
         sd3_ff <= sd2_ff;

         // opposite signs of a and c add, equal signs subtract
         if (sd3_ff) begin
            mag4_ff  <= add_w;
            neg4_ff  <= 1'b0;
            zero4_ff <= (bb_w == '0) && (ac4_w == '0);
         end else begin
            mag4_ff  <= sub_ba[DW-1] ? sub_ab : sub_ba;
            neg4_ff  <= sub_ba[DW-1];
            zero4_ff <= (bb_w == ac4_w);
         end
         am4_ff <= am3_ff;
         bm4_ff <= bm3_ff;
         an4_ff <= an3_ff;
         bn4_ff <= bn3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_mag   = mag4_ff;
   assign out_neg   = neg4_ff;
   assign out_zero  = zero4_ff;
   assign out_am    = am4_ff;
   assign out_aneg  = an4_ff;
   assign out_bm    = bm4_ff;
   assign out_bneg  = bn4_ff;

endmodule

// ===== design/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
   parameter int SW    = 49,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2*SW-1:0]   in_rad,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [SW-1:0]     out_root,
   output logic [TAG_W-1:0]  out_tag
);

   localparam int RMW = SW + 2;

   logic             v_ff    [SW];
   logic [RMW-1:0]   rem_ff  [SW];
   logic [SW-1:0]    root_ff [SW];
   logic [2*SW-1:0]  rad_ff  [SW];
   logic [TAG_W-1:0] tag_ff  [SW];

   for (genvar k = 0; k < SW; k++) begin : g_stage
      logic             v_src;
      logic [RMW-1:0]   rem_src;
      logic [SW-1:0]    root_src;
      logic [2*SW-1:0]  rad_src;
      logic [TAG_W-1:0] tag_src;
      logic [RMW+1:0]   sh, trial;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
         assign tag_src  = in_tag;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign tag_src  = tag_ff[k-1];
      end

      assign sh    = {rem_src, rad_src[2*SW-1 -: 2]};
      assign trial = sh - {2'b00, root_src, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!trial[RMW+1]) begin
               rem_ff[k]  <= trial[RMW-1:0];
               root_ff[k] <= {root_src[SW-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= sh[RMW-1:0];
               root_ff[k] <= {root_src[SW-2:0], 1'b0};
            end
            rad_ff[k] <= rad_src << 2;
            tag_ff[k] <= tag_src;
         end
      end
   end

   assign out_valid = v_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_tag   = tag_ff[SW-1];

endmodule

// ===== design/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage. Quotient bits
// shift in where numerator bits shift out.
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int NUMW  = 52,
   parameter int DENW  = 34,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUMW-1:0]   in_num,
   input  logic [DENW-1:0]   in_den,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [NUMW-1:0]   out_quo,
   output logic [TAG_W-1:0]  out_tag
);

   logic             v_ff   [NUMW];
   logic [DENW-1:0]  rem_ff [NUMW];
   logic [NUMW-1:0]  nq_ff  [NUMW];
   logic [DENW-1:0]  den_ff [NUMW];
   logic [TAG_W-1:0] tag_ff [NUMW];

   for (genvar k = 0; k < NUMW; k++) begin : g_stage
      logic             v_src;
      logic [DENW-1:0]  rem_src, den_src;
      logic [NUMW-1:0]  nq_src;
      logic [TAG_W-1:0] tag_src;
      logic [DENW:0]    sh, diff;
      logic             ge;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = '0;
         assign nq_src  = in_num;
         assign den_src = in_den;
         assign tag_src = in_tag;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign nq_src  = nq_ff[k-1];
         assign den_src = den_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      assign sh   = {rem_src, nq_src[NUMW-1]};
      assign diff = sh - {1'b0, den_src};
      assign ge   = (sh >= {1'b0, den_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DENW-1:0] : sh[DENW-1:0];
            nq_ff[k]  <= {nq_src[NUMW-2:0], ge};
            den_ff[k] <= den_src;
            tag_ff[k] <= tag_src;
         end
      end
   end

   assign out_valid = v_ff[NUMW-1];
   assign out_quo   = nq_ff[NUMW-1];
   assign out_tag   = tag_ff[NUMW-1];

endmodule
